[rtl/vcm_pkg.sv]
// ----------------------------------------------------------------------------
// vcm_pkg
// Types, constants and register codes shared by the variant call merge table.
// ----------------------------------------------------------------------------
package vcm_pkg;

   // default sizing
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int MAX_CALLERS_DEF = 8;

   // field widths fixed by the interface
   localparam int CHROM_W = 8;
   localparam int POS_W   = 31;
   localparam int TYPE_W  = 4;
   localparam int CID_W   = 3;
   localparam int IDX_W   = 10;
   localparam int OMASK_W = 8;
   localparam int HITS_W  = 16;
   localparam int MINC_W  = 4;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_ADDR_W-1:0] CSR_MATCH_DISTANCE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_CALLERS    = 2'd1;
   localparam logic [POS_W-1:0]      DIST_RESET         = 31'd1000;
   localparam logic [MINC_W-1:0]     MINC_RESET         = 4'd2;

   // item kinds
   localparam logic KIND_SUBMIT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // type code that matches on a single near breakpoint pair
   localparam logic [TYPE_W-1:0] ONE_BP_TYPE = 4'd4;

   // saturation value of the hit counter
   localparam logic [HITS_W-1:0] HITS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [CHROM_W-1:0] chrom;
      logic [POS_W-1:0]   pos;
   } point_type;

   typedef struct packed {
      logic               kind;
      logic [CHROM_W-1:0] start_chrom;
      logic [POS_W-1:0]   start_pos;
      logic [CHROM_W-1:0] stop_chrom;
      logic [POS_W-1:0]   stop_pos;
      logic [TYPE_W-1:0]  sv_type;
      logic [CID_W-1:0]   caller_num;
      logic [IDX_W-1:0]   entry_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   slot;
      logic               matched;
      logic               dropped;
      logic               entry_valid;
      logic [CHROM_W-1:0] entry_start_chrom;
      logic [POS_W-1:0]   entry_start_pos;
      logic [CHROM_W-1:0] entry_stop_chrom;
      logic [POS_W-1:0]   entry_stop_pos;
      logic [TYPE_W-1:0]  entry_type;
      logic [OMASK_W-1:0] support_mask;
      logic [HITS_W-1:0]  hit_count;
      logic               passes;
   } rsp_type;

   // fixed-width part of a stored entry, the support mask is appended below it
   typedef struct packed {
      point_type         start_pt;
      point_type         stop_pt;
      logic [TYPE_W-1:0] sv_type;
      logic [HITS_W-1:0] hits;
   } ent_fix_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_FETCH,
      ST_RD_DONE,
      ST_FETCH,
      ST_CMP_A,
      ST_CMP_B,
      ST_CMP_C,
      ST_MATCH,
      ST_APPEND
   } state_type;

endpackage

[rtl/variant_call_merge_table.sv]
// ----------------------------------------------------------------------------
// variant_call_merge_table
// Merges structural variant calls into a table of distinct events.
// Read item: fetches the addressed entry (ST_RD_FETCH), then loads the result (ST_RD_DONE).
// Submit item with n stored entries: per entry scanned, one RAM read, then up to three
// passes through the single breakpoint comparator; then a match update or an append.
// One item at a time; the output register lets the next item enter early.
// Synchronous reset empties the table and restores register defaults at once.
// ----------------------------------------------------------------------------
module variant_call_merge_table
   import vcm_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_CALLERS = MAX_CALLERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW      = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int MASK_W  = (MAX_CALLERS < OMASK_W) ? MAX_CALLERS : OMASK_W;
   localparam int FIX_W   = $bits(ent_fix_type);
   localparam int ENTRY_W = FIX_W + MASK_W;
   localparam int CALL_W  = 7;

   state_type          state_ff, state_in;
   req_type            req_ff;
   logic [CNT_W-1:0]   e_ff, e_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               a_hit_ff, a_hit_in;
   logic [POS_W-1:0]   dist_ff, dist_in;
   logic [MINC_W-1:0]  minc_ff, minc_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_take;
   logic               out_free;
   logic [ENTRY_W-1:0] rd_data;
   ent_fix_type        ent_fix;
   logic [MASK_W-1:0]  ent_mask;
   logic [AW-1:0]      rd_addr;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   point_type          cmp_a, cmp_b;
   logic               near;
   logic               type_eq;
   logic               one_bp;
   logic               last_entry;
   logic               table_full;
   logic               in_range;
   logic               nonzero;
   logic               cid_ok;
   logic [OMASK_W-1:0] cid_bit;
   logic [OMASK_W-1:0] mask_ext;
   logic [OMASK_W-1:0] upd_mask;
   logic [MASK_W-1:0]  new_mask;
   logic [HITS_W-1:0]  new_hits;
   ent_fix_type        new_fix;
   logic [CMP_W-1:0]   idx_wide;
   logic [CMP_W-1:0]   e_wide;
   logic [CMP_W-1:0]   cnt_wide;
   logic               step;
   logic               rsp_load;

   // number of set support bits
   function automatic logic [MINC_W-1:0] pop_f(input logic [MASK_W-1:0] m);
      logic [MINC_W-1:0] n;
      n = '0;
      for (int i = 0; i < MASK_W; i++) begin
         n = n + MINC_W'(m[i]);
      end
      return n;
   endfunction

   // entry fields of a result
   function automatic rsp_type report_f(input ent_fix_type f, input logic [MASK_W-1:0] m,
                                        input logic [MINC_W-1:0] minc);
      rsp_type r;
      r                   = '0;
      r.entry_valid       = 1'b1;
      r.entry_start_chrom = f.start_pt.chrom;
      r.entry_start_pos   = f.start_pt.pos;
      r.entry_stop_chrom  = f.stop_pt.chrom;
      r.entry_stop_pos    = f.stop_pt.pos;
      r.entry_type        = f.sv_type;
      r.support_mask      = OMASK_W'(m);
      r.hit_count         = f.hits;
      r.passes            = (pop_f(m) >= minc);
      return r;
   endfunction

   // entry storage
   vcm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared breakpoint comparator
   vcm_point_cmp u_cmp (
      .point_a  (cmp_a),
      .point_b  (cmp_b),
      .distance (dist_ff),
      .near     (near)
   );

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // entry decode and call attributes
   assign ent_fix    = ent_fix_type'(rd_data[ENTRY_W-1:MASK_W]);
   assign ent_mask   = rd_data[MASK_W-1:0];
   assign type_eq    = (ent_fix.sv_type == req_ff.sv_type);
   assign one_bp     = (req_ff.sv_type == ONE_BP_TYPE);
   assign nonzero    = (req_ff.start_pos != req_ff.stop_pos);
   assign cid_ok     = (CALL_W'(req_ff.caller_num) < CALL_W'(MAX_CALLERS));
   assign cid_bit    = OMASK_W'(1) << req_ff.caller_num;
   assign idx_wide   = CMP_W'(req_ff.entry_index);
   assign e_wide     = CMP_W'(e_ff);
   assign cnt_wide   = CMP_W'(cnt_ff);
   assign in_range   = (idx_wide < cnt_wide);
   assign last_entry = ((e_ff + CNT_W'(1)) == cnt_ff);
   assign table_full = (cnt_ff == CNT_W'(TABLE_DEPTH));

   // comparator operand select
   always_comb begin
      cmp_a = {req_ff.start_chrom, req_ff.start_pos};
      cmp_b = ent_fix.start_pt;
      case (state_ff)
         ST_CMP_B: begin
            cmp_a = {req_ff.stop_chrom, req_ff.stop_pos};
            cmp_b = a_hit_ff ? ent_fix.stop_pt : ent_fix.start_pt;
         end
         ST_CMP_C: begin
            cmp_b = ent_fix.stop_pt;
         end
         default: begin
         end
      endcase
   end

   // support and hit update of a matched entry, or the mask of a new one
   always_comb begin
      mask_ext = OMASK_W'(ent_mask);
      if (state_ff == ST_MATCH) begin
         upd_mask = mask_ext;
         if (cid_ok) begin
            upd_mask = nonzero ? (mask_ext | cid_bit) : (mask_ext & ~cid_bit);
         end
         new_hits = (ent_fix.hits == HITS_MAX) ? ent_fix.hits : ent_fix.hits + HITS_W'(1);
         new_fix  = ent_fix;
      end else begin
         upd_mask         = (nonzero && cid_ok) ? cid_bit : '0;
         new_hits         = HITS_W'(1);
         new_fix.start_pt = {req_ff.start_chrom, req_ff.start_pos};
         new_fix.stop_pt  = {req_ff.stop_chrom, req_ff.stop_pos};
         new_fix.sv_type  = req_ff.sv_type;
      end
      new_fix.hits = new_hits;
      new_mask     = upd_mask[MASK_W-1:0];
   end

   // move on to the next entry when the current one fails
   always_comb begin
      step = 1'b0;
      case (state_ff)
         ST_CMP_A: step = !type_eq;
         ST_CMP_B: step = !near;
         ST_CMP_C: step = !near;
         default:  step = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.kind == KIND_READ) begin
                  state_in = ST_RD_FETCH;
               end else if (cnt_ff == '0) begin
                  state_in = ST_APPEND;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_RD_FETCH: state_in = ST_RD_DONE;
         ST_RD_DONE:  state_in = out_free ? ST_IDLE : ST_RD_DONE;
         ST_FETCH:    state_in = ST_CMP_A;
         ST_CMP_A: begin
            if (type_eq) begin
               state_in = (near && one_bp) ? ST_MATCH : ST_CMP_B;
            end
         end
         ST_CMP_B: begin
            if (near) begin
               state_in = (a_hit_ff || one_bp) ? ST_MATCH : ST_CMP_C;
            end
         end
         ST_CMP_C: begin
            if (near) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH:  state_in = out_free ? ST_IDLE : ST_MATCH;
         ST_APPEND: state_in = out_free ? ST_IDLE : ST_APPEND;
         default:   state_in = ST_IDLE;
      endcase
      if (step) begin
         state_in = last_entry ? ST_APPEND : ST_FETCH;
      end
   end

   // outputs: RAM ports, result and counters
   always_comb begin
      rd_addr   = e_ff[AW-1:0];
      ram_we    = 1'b0;
      ram_waddr = e_ff[AW-1:0];
      ram_wdata = {new_fix, new_mask};
      rsp_load  = 1'b0;
      rsp_in    = '0;
      e_in      = step ? e_ff + CNT_W'(1) : e_ff;
      cnt_in    = cnt_ff;
      a_hit_in  = a_hit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               e_in = '0;
            end
         end
         ST_RD_FETCH: begin
            rd_addr = idx_wide[AW-1:0];
         end
         ST_RD_DONE: begin
            // keep the read entry on the RAM output while the result waits
            rd_addr  = idx_wide[AW-1:0];
            rsp_load = out_free;
            if (in_range) begin
               rsp_in = report_f(ent_fix, ent_mask, minc_ff);
            end
            rsp_in.slot = req_ff.entry_index;
         end
         ST_CMP_A: begin
            a_hit_in = near;
         end
         ST_MATCH: begin
            ram_we         = out_free;
            rsp_load       = out_free;
            rsp_in         = report_f(new_fix, new_mask, minc_ff);
            rsp_in.slot    = e_wide[IDX_W-1:0];
            rsp_in.matched = 1'b1;
         end
         ST_APPEND: begin
            rsp_load  = out_free;
            ram_waddr = cnt_ff[AW-1:0];
            if (table_full) begin
               rsp_in.dropped = 1'b1;
            end else begin
               ram_we      = out_free;
               rsp_in      = report_f(new_fix, new_mask, minc_ff);
               rsp_in.slot = cnt_wide[IDX_W-1:0];
               if (out_free) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      dist_in = dist_ff;
      minc_in = minc_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_MATCH_DISTANCE: dist_in = csr_wdata;
            CSR_MIN_CALLERS:    minc_in = csr_wdata[MINC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dist_ff      <= DIST_RESET;
         minc_ff      <= MINC_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         dist_ff      <= dist_in;
         minc_ff      <= minc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      e_ff     <= e_in;
      a_hit_ff <= a_hit_in;
   end

endmodule

[rtl/vcm_ram.sv]
// ----------------------------------------------------------------------------
// vcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/vcm_point_cmp.sv]
// ----------------------------------------------------------------------------
// vcm_point_cmp
// Shared breakpoint comparator: same chromosome and |pos_a - pos_b| < distance.
// ----------------------------------------------------------------------------
module vcm_point_cmp
   import vcm_pkg::*;
(
   input  point_type        point_a,
   input  point_type        point_b,
   input  logic [POS_W-1:0] distance,
   output logic             near
);

   logic [POS_W:0] a_ext;
   logic [POS_W:0] b_ext;
   logic [POS_W:0] a_plus_d;
   logic [POS_W:0] b_plus_d;

   // a - b < d and b - a < d, done as two sums compared in parallel
   assign a_ext    = {1'b0, point_a.pos};
   assign b_ext    = {1'b0, point_b.pos};
   assign a_plus_d = a_ext + {1'b0, distance};
   assign b_plus_d = b_ext + {1'b0, distance};

   assign near = (point_a.chrom == point_b.chrom) && (a_ext < b_plus_d) && (b_ext < a_plus_d);

endmodule
